// File: hdl/msbr_pkg.sv
// Shared types and constants of the MSB-first bitstream reader.
package msbr_pkg;

  // Ring store geometry
  localparam int unsigned BufDepth = 4096;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned CntW     = AddrW + 1;

  // Operation codes
  localparam logic [2:0] OpPush   = 3'd0;
  localparam logic [2:0] OpGet    = 3'd1;
  localparam logic [2:0] OpSkip   = 3'd2;
  localparam logic [2:0] OpSave   = 3'd3;
  localparam logic [2:0] OpRewind = 3'd4;

  // Status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNeed = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [5:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [31:0] field_value;
    logic [1:0]  status;
  } rsp_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    CtlIdle   = 4'b0001,
    CtlDecode = 4'b0010,
    CtlFetch  = 4'b0100,
    CtlFinish = 4'b1000
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic fetch;
    logic finish;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_fetch;
    logic fetch_last;
  } dp_sts_t;

endpackage

// File: hdl/msbr_ctrl.sv
// Controller state machine of the bitstream reader.
module msbr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  msbr_pkg::dp_sts_t sts_i,
  output msbr_pkg::ctl_cmd_t cmd_o,
  output logic             busy
);
  import msbr_pkg::*;

  ctl_state_e state_q, state_d;

  // Advance through decode, byte fetch and finish
  always_comb begin
    state_d = state_q;
    case (state_q)
      CtlIdle: begin
        if (start) state_d = CtlDecode;
      end
      CtlDecode: begin
        state_d = sts_i.need_fetch ? CtlFetch : CtlIdle;
      end
      CtlFetch: begin
        if (sts_i.fetch_last) state_d = CtlFinish;
      end
      CtlFinish: begin
        state_d = CtlIdle;
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd_o.latch  = (state_q == CtlIdle) && start;
    cmd_o.decode = (state_q == CtlDecode);
    cmd_o.fetch  = (state_q == CtlFetch);
    cmd_o.finish = (state_q == CtlFinish);
  end

  assign busy = (state_q != CtlIdle);

endmodule

// File: hdl/msbr_dp.sv
// Datapath of the bitstream reader: ring store, positions, byte window, result.
module msbr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msbr_pkg::req_t     req_i,
  input  msbr_pkg::ctl_cmd_t cmd_i,
  output msbr_pkg::dp_sts_t  sts_o,
  output logic               res_valid_o,
  output msbr_pkg::rsp_t     res_o
);
  import msbr_pkg::*;

  localparam logic [2:0] FetchBytes = 3'd5;

  // Step a ring position forward by up to four bytes
  function automatic logic [AddrW-1:0] ring_inc(input logic [AddrW-1:0] pos,
                                                input logic [2:0] k);
    logic [CntW-1:0] sum;
    sum = {1'b0, pos} + CntW'(k);
    if (sum >= CntW'(BufDepth)) sum = sum - CntW'(BufDepth);
    return sum[AddrW-1:0];
  endfunction

  logic [7:0] mem [BufDepth];

  req_t            req_q, req_d;
  logic [AddrW-1:0] wpos_q, wpos_d, parse_q, parse_d, ckpt_q, ckpt_d;
  logic [CntW-1:0]  held_q, held_d;
  logic [2:0]       bl_q, bl_d, cbl_q, cbl_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic [7:0]       rd_data_q;
  logic [39:0]      win_q, win_d;
  logic             res_valid_q, res_valid_d;
  rsp_t             res_q, res_d;
  logic             wr_en, rd_en;

  req_t             req_clamped;
  logic [CntW-1:0]  offset, ahead;
  logic [AddrW-1:0] parse_prev;
  logic             long_n, short_get;
  logic [5:0]       rem;
  logic [2:0]       k_bytes, bl_new;
  logic [6:0]       sh;
  logic [39:0]      win_eff, shifted;
  logic [31:0]      mask;

  // Clamp the bit count to 32
  always_comb begin
    req_clamped = req_i;
    if (req_i.bit_count > 6'd32) req_clamped.bit_count = 6'd32;
  end

  // Bytes buffered beyond the parse position
  always_comb begin
    offset = {1'b0, parse_q} - {1'b0, ckpt_q};
    if (parse_q < ckpt_q) offset = offset + CntW'(BufDepth);
    ahead = (held_q > offset) ? held_q - offset : '0;
    parse_prev = (parse_q == '0) ? AddrW'(BufDepth - 1) : parse_q - AddrW'(1);
  end

  // Bits beyond the partly read byte and the bytes they span
  always_comb begin
    long_n    = req_q.bit_count > {3'b000, bl_q};
    rem       = req_q.bit_count - {3'b000, bl_q};
    k_bytes   = 3'((7'(rem) + 7'd7) >> 3);
    bl_new    = 3'({k_bytes, 3'b000} - rem);
    short_get = long_n && (ahead < CntW'(4));
  end

  // Extract the field from the last byte and the four-byte window
  always_comb begin
    win_eff = {((bl_q == 3'd0) ? 8'h00 : win_q[39:32]), win_q[31:0]};
    sh      = 7'd32 + 7'(bl_q) - 7'(req_q.bit_count);
    shifted = win_eff >> sh;
    mask    = 32'hFFFF_FFFF >> (6'd32 - req_q.bit_count);
  end

  assign sts_o.need_fetch = (req_q.operation == OpGet) && !short_get;
  assign sts_o.fetch_last = (cnt_q == FetchBytes);

  // Next-state logic for every operation
  always_comb begin
    req_d       = req_q;
    wpos_d      = wpos_q;
    parse_d     = parse_q;
    ckpt_d      = ckpt_q;
    held_d      = held_q;
    bl_d        = bl_q;
    cbl_d       = cbl_q;
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    win_d       = win_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    if (cmd_i.latch) req_d = req_clamped;

    if (cmd_i.decode) begin
      res_d.field_value = '0;
      res_d.status      = StOk;
      res_valid_d       = 1'b1;
      case (req_q.operation)
        OpPush: begin
          if (held_q >= CntW'(BufDepth - 1)) begin
            res_d.status = StFull;
          end else begin
            wr_en  = 1'b1;
            wpos_d = ring_inc(wpos_q, 3'd1);
            held_d = held_q + CntW'(1);
          end
        end
        OpGet: begin
          if (short_get) begin
            parse_d      = ckpt_q;
            bl_d         = cbl_q;
            res_d.status = StNeed;
          end else begin
            // hold the result until the window is in
            res_valid_d = 1'b0;
            rd_addr_d   = parse_prev;
            cnt_d       = '0;
          end
        end
        OpSkip: begin
          if (!long_n) begin
            bl_d = bl_q - 3'(req_q.bit_count);
          end else if (ahead < CntW'(k_bytes)) begin
            parse_d      = ckpt_q;
            bl_d         = cbl_q;
            res_d.status = StNeed;
          end else begin
            parse_d = ring_inc(parse_q, k_bytes);
            bl_d    = bl_new;
          end
        end
        OpSave: begin
          held_d = ahead;
          ckpt_d = parse_q;
          cbl_d  = bl_q;
        end
        OpRewind: begin
          parse_d = ckpt_q;
          bl_d    = cbl_q;
        end
        default: begin
        end
      endcase
    end

    // Read the last byte and the window, one byte a cycle
    if (cmd_i.fetch) begin
      rd_en = (cnt_q < FetchBytes);
      if (rd_en) rd_addr_d = ring_inc(rd_addr_q, 3'd1);
      if (cnt_q != '0) win_d = {win_q[31:0], rd_data_q};
      cnt_d = cnt_q + 3'd1;
    end

    // Deliver the field and advance the parse position
    if (cmd_i.finish) begin
      res_d.field_value = shifted[31:0] & mask;
      res_d.status      = StOk;
      res_valid_d       = 1'b1;
      if (!long_n) begin
        bl_d = bl_q - 3'(req_q.bit_count);
      end else begin
        parse_d = ring_inc(parse_q, k_bytes);
        bl_d    = bl_new;
      end
    end
  end

  // Ring store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wpos_q] <= req_q.data_byte;
    if (rd_en) rd_data_q <= mem[rd_addr_q];
  end

  // Control and position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      parse_q     <= '0;
      ckpt_q      <= '0;
      held_q      <= '0;
      bl_q        <= '0;
      cbl_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      wpos_q      <= wpos_d;
      parse_q     <= parse_d;
      ckpt_q      <= ckpt_d;
      held_q      <= held_d;
      bl_q        <= bl_d;
      cbl_q       <= cbl_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rd_addr_q <= rd_addr_d;
    win_q     <= win_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hdl/msb_first_bitstream_reader_core.sv
// Top level of the MSB-first bitstream reader with checkpoint.
//
// Command channel: drive req_i and raise start; the command transfers at the
// rising edge where start is high and busy is low. Operations are push byte,
// get bits, skip bits, save checkpoint and rewind to checkpoint.
// Result channel: res_valid_o is high for exactly one cycle and res_o holds
// the field value and status in that cycle; the receiver cannot stall it.
// Sequence: push, skip, save, rewind, unknown operations and a get that finds
// too few bytes give their result from the decode state, registered after the
// transfer. A get that reads bytes passes through the fetch and finish states
// first: the single-port ring store delivers one byte per cycle, and the last
// partly read byte plus the four-byte window take five reads. busy drops in
// the cycle the result appears, so the next command can transfer then; no new
// command is taken while one is still in progress.
// Reset clears all positions, counts and the checkpoint; the ring store
// content is left as is and only written bytes ever reach a result.
module msb_first_bitstream_reader_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  msbr_pkg::req_t  req_i,
  output logic            busy,
  output logic            res_valid_o,
  output msbr_pkg::rsp_t  res_o
);
  import msbr_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequence each transfer
  msbr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Store bytes and compute results
  msbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
